FILE: rtl/core/hcb_pkg.sv
// Shared types and default constants for the Huffman code builder.
`timescale 1ns / 1ps
package hcb_pkg;
	localparam int DefMaxSymbols = 32;
	localparam int DefFreqBits   = 24;
	localparam int SymBits       = 8;
	localparam int FreqPortBits  = 24;
	localparam int LenBits       = 5;
	localparam int CodeBits      = 31;

	// Operation applied to every cell of the DFS stack chain at once.
	typedef enum logic [1:0] {
		STK_HOLD,
		STK_PUSH,
		STK_POP
	} stk_op_t;
endpackage

FILE: rtl/core/hcb_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module hcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/hcb_stack_cell.sv
// One cell of the shift-register stack used for the depth-first code walk.
`timescale 1ns / 1ps
module hcb_stack_cell #(
	parameter int EW = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hcb_pkg::stk_op_t       op,
	input  logic                   prev_vld,
	input  logic [EW-1:0]          prev_ent,
	input  logic                   next_vld,
	input  logic [EW-1:0]          next_ent,
	output logic                   vld,
	output logic [EW-1:0]          ent
);
	import hcb_pkg::*;

	// A push takes the entry from the cell above, a pop takes it from below.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= 1'b0;
		end else begin
			case (op)
				STK_PUSH: vld <= prev_vld;
				STK_POP:  vld <= next_vld;
				default:  vld <= vld;
			endcase
		end
	end

	// The payload follows the same moves and needs no reset.
	always_ff @(posedge clk) begin
		case (op)
			STK_PUSH: ent <= prev_ent;
			STK_POP:  ent <= next_ent;
			default:  ent <= ent;
		endcase
	end
endmodule

FILE: rtl/core/huffman_code_builder.sv
// Huffman code builder: loads symbols, builds the tree by a binary min-heap, walks it.
// Symbols load one per cycle; after the final beat heapify sifts down each node from
// index N/2 to the root, then N-1 merges build the tree from the heap and a depth-first
// walk emits the N codes; results leave on one-cycle strobes and cannot be stalled.
// Reset clears the control state and the stack valid bits; the RAMs hold data until written.
`timescale 1ns / 1ps
module huffman_code_builder #(
	parameter int MAX_SYMBOLS = hcb_pkg::DefMaxSymbols,
	parameter int FREQ_BITS   = hcb_pkg::DefFreqBits
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [hcb_pkg::SymBits-1:0]       symbol,
	input  logic [hcb_pkg::FreqPortBits-1:0]  frequency,
	input  logic                              final_entry,
	output logic                              code_valid,
	output logic [hcb_pkg::SymBits-1:0]       code_symbol,
	output logic [hcb_pkg::LenBits-1:0]       code_length,
	output logic [hcb_pkg::CodeBits-1:0]      code_bits,
	output logic                              final_code,
	output logic                              overflowed
);
	import hcb_pkg::*;

	localparam int FU   = (FREQ_BITS < FreqPortBits) ? FREQ_BITS : FreqPortBits;
	localparam int WW   = FREQ_BITS + $clog2(MAX_SYMBOLS);
	localparam int ND   = 2 * MAX_SYMBOLS;
	localparam int NW   = $clog2(ND);
	localparam int HW   = $clog2(MAX_SYMBOLS);
	localparam int CW   = $clog2(MAX_SYMBOLS + 1);
	localparam int HEW  = WW + NW;
	localparam int NEW  = 1 + SymBits + 2 * NW;
	localparam int EW   = NW + LenBits + CodeBits;

	typedef enum logic [4:0] {
		S_IDLE, S_HEAP, S_SD_LOAD, S_SD_FETCH, S_SD_START, S_SD_R, S_SD_CMP, S_SD_END,
		S_POP0, S_POP1, S_POP2, S_MCHK, S_MWR, S_PU_START, S_PU_CMP, S_ROOT,
		S_WPOP, S_WNODE, S_WLEFT, S_WDONE
	} state_t;

	typedef enum logic [1:0] {
		RET_HEAP, RET_POPA, RET_POPB
	} ret_t;

	state_t          state_q;
	ret_t            ret_q;
	logic [CW-1:0]   cnt_q;
	logic            ovf_q;
	logic [CW-1:0]   size_q;
	logic [HW-1:0]   idx_q;
	logic [HW-1:0]   pos_q;
	logic [NW-1:0]   next_q;
	logic [HEW-1:0]  cur_q;
	logic [HEW-1:0]  lv_q;
	logic [HEW-1:0]  a_q;
	logic [HEW-1:0]  b_q;
	logic [HEW-1:0]  new_q;
	logic [EW-1:0]   e_q;

	// Heap and node RAM ports.
	logic            hp_we;
	logic [HW-1:0]   hp_waddr;
	logic [HEW-1:0]  hp_wdata;
	logic [HW-1:0]   hp_raddr;
	logic [HEW-1:0]  hp_rdata;
	logic            nd_we;
	logic [NW-1:0]   nd_waddr;
	logic [NEW-1:0]  nd_wdata;
	logic [NW-1:0]   nd_raddr;
	logic [NEW-1:0]  nd_rdata;

	// Stack chain.
	stk_op_t         stk_op;
	logic [EW-1:0]   stk_in;
	logic            stk_vld [MAX_SYMBOLS+1];
	logic [EW-1:0]   stk_ent [MAX_SYMBOLS+1];

	logic            accept;
	logic [CW-1:0]   n_next;
	logic [HW:0]     lidx;
	logic [HW:0]     ridx;
	logic            lok;
	logic            rok;
	logic [HW-1:0]   par;
	logic [HEW-1:0]  best_v;
	logic [HW-1:0]   best_i;
	logic            best_moved;

	hcb_ram #(.WIDTH(HEW), .DEPTH(MAX_SYMBOLS)) u_heap_ram (
		.clk(clk), .we(hp_we), .waddr(hp_waddr), .wdata(hp_wdata),
		.raddr(hp_raddr), .rdata(hp_rdata)
	);

	hcb_ram #(.WIDTH(NEW), .DEPTH(ND)) u_node_ram (
		.clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
		.raddr(nd_raddr), .rdata(nd_rdata)
	);

	// Row of stack cells; cell 0 is the top of the stack.
	assign stk_vld[MAX_SYMBOLS] = 1'b0;
	assign stk_ent[MAX_SYMBOLS] = '0;
	for (genvar g = 0; g < MAX_SYMBOLS; g++) begin : g_cell
		logic          pv;
		logic [EW-1:0] pe;
		if (g == 0) begin : g_top
			assign pv = 1'b1;
			assign pe = stk_in;
		end else begin : g_mid
			assign pv = stk_vld[g-1];
			assign pe = stk_ent[g-1];
		end
		hcb_stack_cell #(.EW(EW)) u_cell (
			.clk(clk), .arst_n(arst_n), .op(stk_op),
			.prev_vld(pv), .prev_ent(pe),
			.next_vld(stk_vld[g+1]), .next_ent(stk_ent[g+1]),
			.vld(stk_vld[g]), .ent(stk_ent[g])
		);
	end

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign n_next = (cnt_q < CW'(MAX_SYMBOLS)) ? cnt_q + CW'(1) : cnt_q;

	// Child and parent positions of the heap walk.
	assign lidx = {pos_q, 1'b1};
	assign ridx = lidx + (HW+1)'(1);
	assign lok  = ((CW+1)'(lidx) < (CW+1)'(size_q));
	assign rok  = ((CW+1)'(ridx) < (CW+1)'(size_q));
	assign par  = HW'((idx_q - HW'(1)) >> 1);

	// Pick the smallest of the held element and its two children, strict less-than.
	always_comb begin
		best_v     = cur_q;
		best_i     = pos_q;
		best_moved = 1'b0;
		if (lv_q[HEW-1:NW] < best_v[HEW-1:NW]) begin
			best_v     = lv_q;
			best_i     = HW'(lidx);
			best_moved = 1'b1;
		end
		if (rok && (hp_rdata[HEW-1:NW] < best_v[HEW-1:NW])) begin
			best_v     = hp_rdata;
			best_i     = HW'(ridx);
			best_moved = 1'b1;
		end
	end

	// RAM and stack control decoded from the sequencer state.
	always_comb begin
		hp_we    = 1'b0;
		hp_waddr = pos_q;
		hp_wdata = cur_q;
		hp_raddr = pos_q;
		nd_we    = 1'b0;
		nd_waddr = next_q;
		nd_wdata = {1'b0, SymBits'(0), a_q[NW-1:0], b_q[NW-1:0]};
		nd_raddr = stk_ent[0][EW-1:LenBits+CodeBits];
		stk_op   = STK_HOLD;
		stk_in   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (cnt_q < CW'(MAX_SYMBOLS))) begin
					hp_we    = 1'b1;
					hp_waddr = HW'(cnt_q);
					hp_wdata = {WW'(frequency[FU-1:0]), NW'(cnt_q)};
					nd_we    = 1'b1;
					nd_waddr = NW'(cnt_q);
					nd_wdata = {1'b1, symbol, NW'(0), NW'(0)};
				end
			end
			S_SD_START: hp_raddr = HW'(lidx);
			S_SD_R:     hp_raddr = HW'(ridx);
			S_SD_CMP: begin
				if (best_moved) begin
					hp_we    = 1'b1;
					hp_wdata = best_v;
				end
			end
			S_SD_END: hp_we = 1'b1;
			S_POP0:   hp_raddr = '0;
			S_POP1:   hp_raddr = HW'(size_q - CW'(1));
			S_MCHK:   hp_raddr = '0;
			S_MWR:    nd_we = 1'b1;
			S_PU_START: begin
				hp_raddr = par;
				if (idx_q == '0) begin
					hp_we    = 1'b1;
					hp_waddr = '0;
					hp_wdata = new_q;
				end
			end
			S_PU_CMP: begin
				hp_we    = 1'b1;
				hp_waddr = idx_q;
				hp_wdata = (new_q[HEW-1:NW] < hp_rdata[HEW-1:NW]) ? hp_rdata : new_q;
			end
			S_ROOT: begin
				stk_op = STK_PUSH;
				stk_in = {hp_rdata[NW-1:0], LenBits'(0), CodeBits'(0)};
			end
			S_WPOP: begin
				if (stk_vld[0]) begin
					stk_op = STK_POP;
				end
			end
			S_WNODE: begin
				// Read the same node again so its left child is still at hand next cycle.
				nd_raddr = e_q[EW-1:LenBits+CodeBits];
				if (!nd_rdata[NEW-1]) begin
					stk_op = STK_PUSH;
					stk_in = {nd_rdata[NW-1:0], e_q[LenBits+CodeBits-1:CodeBits] + LenBits'(1),
						e_q[CodeBits-2:0], 1'b1};
				end
			end
			S_WLEFT: begin
				stk_op = STK_PUSH;
				stk_in = {nd_rdata[2*NW-1:NW], e_q[LenBits+CodeBits-1:CodeBits] + LenBits'(1),
					e_q[CodeBits-2:0], 1'b0};
			end
			default: begin
			end
		endcase
	end

	// Sequencer: load, heapify, merge, then walk the tree.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= RET_HEAP;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			size_q      <= '0;
			idx_q       <= '0;
			pos_q       <= '0;
			next_q      <= '0;
			code_valid  <= 1'b0;
			final_code  <= 1'b0;
			overflowed  <= 1'b0;
			code_symbol <= '0;
			code_length <= '0;
			code_bits   <= '0;
		end else begin
			code_valid <= 1'b0;
			final_code <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= n_next;
						if (cnt_q == CW'(MAX_SYMBOLS)) begin
							ovf_q <= 1'b1;
						end
						if (final_entry) begin
							size_q  <= n_next;
							idx_q   <= HW'(n_next >> 1);
							next_q  <= NW'(n_next);
							ret_q   <= RET_HEAP;
							state_q <= S_HEAP;
						end
					end
				end
				S_HEAP: begin
					pos_q   <= idx_q;
					state_q <= S_SD_LOAD;
				end
				S_SD_LOAD:  state_q <= S_SD_FETCH;
				S_SD_FETCH: begin
					cur_q   <= hp_rdata;
					state_q <= S_SD_START;
				end
				S_SD_START: state_q <= lok ? S_SD_R : S_SD_END;
				S_SD_R: begin
					lv_q    <= hp_rdata;
					state_q <= S_SD_CMP;
				end
				S_SD_CMP: begin
					if (best_moved) begin
						pos_q   <= best_i;
						state_q <= S_SD_START;
					end else begin
						state_q <= S_SD_END;
					end
				end
				S_SD_END: begin
					unique case (ret_q)
						RET_HEAP: begin
							if (idx_q == '0) begin
								state_q <= S_MCHK;
							end else begin
								idx_q   <= idx_q - HW'(1);
								state_q <= S_HEAP;
							end
						end
						RET_POPA: begin
							ret_q   <= RET_POPB;
							state_q <= S_POP0;
						end
						default: state_q <= S_MWR;
					endcase
				end
				S_POP0: state_q <= S_POP1;
				S_POP1: begin
					if (ret_q == RET_POPA) begin
						a_q <= hp_rdata;
					end else begin
						b_q <= hp_rdata;
					end
					state_q <= S_POP2;
				end
				S_POP2: begin
					cur_q   <= hp_rdata;
					size_q  <= size_q - CW'(1);
					pos_q   <= '0;
					state_q <= S_SD_START;
				end
				S_MCHK: begin
					if (size_q > CW'(1)) begin
						ret_q   <= RET_POPA;
						state_q <= S_POP0;
					end else begin
						state_q <= S_ROOT;
					end
				end
				S_MWR: begin
					new_q   <= {WW'(a_q[HEW-1:NW] + b_q[HEW-1:NW]), next_q};
					idx_q   <= HW'(size_q);
					size_q  <= size_q + CW'(1);
					state_q <= S_PU_START;
				end
				S_PU_START: begin
					if (idx_q == '0) begin
						next_q  <= next_q + NW'(1);
						state_q <= S_MCHK;
					end else begin
						state_q <= S_PU_CMP;
					end
				end
				S_PU_CMP: begin
					if (new_q[HEW-1:NW] < hp_rdata[HEW-1:NW]) begin
						idx_q   <= par;
						state_q <= S_PU_START;
					end else begin
						next_q  <= next_q + NW'(1);
						state_q <= S_MCHK;
					end
				end
				S_ROOT: state_q <= S_WPOP;
				S_WPOP: begin
					if (stk_vld[0]) begin
						e_q     <= stk_ent[0];
						state_q <= S_WNODE;
					end else begin
						state_q <= S_WDONE;
					end
				end
				S_WNODE: begin
					if (nd_rdata[NEW-1]) begin
						code_valid  <= 1'b1;
						final_code  <= !stk_vld[0];
						overflowed  <= ovf_q;
						code_symbol <= nd_rdata[NEW-2:2*NW];
						code_length <= e_q[LenBits+CodeBits-1:CodeBits];
						code_bits   <= e_q[CodeBits-1:0];
						state_q     <= S_WPOP;
					end else begin
						state_q <= S_WLEFT;
					end
				end
				S_WLEFT: state_q <= S_WPOP;
				S_WDONE: begin
					cnt_q   <= '0;
					ovf_q   <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// Codes are only emitted while a build is running.
	a_code_in_build: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid |-> busy) else $error("code emitted while idle");
	// The last-code mark never stands without a code.
	a_final_marked: assert property (@(posedge clk) disable iff (!arst_n)
		final_code |-> code_valid) else $error("final_code without code_valid");
	// The walk stack is empty whenever the block is idle.
	a_stack_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !stk_vld[0]) else $error("stack not empty while idle");
	// The load count never passes capacity.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_SYMBOLS)) else $error("load count beyond capacity");
`endif
endmodule
